// ----- rtl/nfs_pkg.sv -----
// Shared types, codes and helpers for the NoC packet-to-flit splitter.
// No dependencies; imported by nfs_flit_fifo and noc_packet_to_flit_splitter.
`timescale 1ns / 1ps

package nfs_pkg;

	// Flit geometry and transaction limits
	localparam int BYTES_PER_FLIT = 8;
	localparam int BPF_LOG2       = $clog2(BYTES_PER_FLIT);
	localparam int MAX_LENGTH     = 4096;

	// Result queue depth (power of two, at least 4 so two flits fit behind a stalled one)
	localparam int FIFO_DEPTH     = 4;

	// Input item kinds (s_tuser)
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_BYTE   = 1'b1;

	// Flit kinds (m_tuser)
	localparam logic [1:0] KIND_HEAD = 2'd0;
	localparam logic [1:0] KIND_BODY = 2'd1;
	localparam logic [1:0] KIND_TAIL = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  source_node;
		logic [7:0]  dest;
		logic [9:0]  seq_number;
		logic [9:0]  seq_length;
		logic [1:0]  command;
		logic [31:0] address;
		logic [12:0] length;
		logic [63:0] payload;
		logic [3:0]  valid_bytes;
		logic        broadcast;
		logic        reduction;
	} flit_t;

	// Flits in a packet: ceil(len / BYTES_PER_FLIT) + head + tail
	function automatic logic [9:0] seq_total(input logic [12:0] len);
		logic [13:0] sum;
		sum = {1'b0, len} + 14'(BYTES_PER_FLIT - 1);
		return 10'(sum >> BPF_LOG2) + 10'd2;
	endfunction

endpackage

// ----- rtl/nfs_flit_fifo.sv -----
// Small result queue for finished flits: takes zero, one or two flits per cycle,
// hands out one per transfer. Depends on nfs_pkg.
`timescale 1ns / 1ps

module nfs_flit_fifo
	import nfs_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  push_n,
	input  flit_t       push_d0,
	input  flit_t       push_d1,
	input  logic        pop,
	output flit_t       head,
	output logic        head_valid,
	output logic        room2
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	flit_t          mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           pop_fire;
	logic [AW-1:0]  wr_ptr_p1;

	assign pop_fire   = pop && (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign room2      = (count_q <= CW'(DEPTH - 2));
	assign wr_ptr_p1  = wr_ptr_q + AW'(1);

	// Storage: up to two consecutive entries per cycle, pointers wrap naturally
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_d1;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_n);
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop_fire);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("flit queue occupancy above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (count_q <= CW'(DEPTH - 2)))
		else $error("flit queue written past its room");

	a_pop_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && push_n == 2'd0) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("flit queue count did not follow a pop");
`endif

endmodule

// ----- rtl/noc_packet_to_flit_splitter.sv -----
// NoC packet-to-flit splitter: header and payload-byte items in, head/body/tail flits out.
// Output: each flit is written to the flit queue when its item is taken and offered on m_* in order.
// Throughput: one item per cycle; s_tready drops only while the 4-entry flit queue
// has fewer than two free entries (an item may cause a second flit).
// Reset: arst_n clears packet state, node_id and the queue at once; no clearing pass.
// Depends on nfs_pkg and nfs_flit_fifo.
`timescale 1ns / 1ps

module noc_packet_to_flit_splitter
	import nfs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// node_id register
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	// dest_node[7:0], command[9:8], address[41:10], length[54:42], broadcast[55],
	// reduction[56], payload_byte[64:57], zero[71:65]
	input  logic [71:0]  s_tdata,
	// operation[0]
	input  logic [0:0]   s_tuser,
	// flits out
	output logic         m_tvalid,
	input  logic         m_tready,
	// source_node[7:0], flit_dest[15:8], seq_number[25:16], seq_length[35:26],
	// flit_command[37:36], flit_address[69:38], flit_length[82:70], payload[146:83],
	// valid_bytes[150:147], bcast_flag[151], flit_reduction[152], zero[159:153]
	output logic [159:0] m_tdata,
	// flit_kind[1:0]
	output logic [1:0]   m_tuser
);

	// Registers
	logic [7:0]  node_id_q;
	logic        collecting_q;
	logic [7:0]  held_dest_q;
	logic [1:0]  held_cmd_q;
	logic [31:0] held_addr_q;
	logic        held_bc_q;
	logic        held_red_q;
	logic [12:0] held_length_q;
	logic [12:0] bytes_taken_q;
	logic [63:0] chunk_q;
	logic [3:0]  chunk_fill_q;
	logic [9:0]  next_seq_q;

	// Input fields
	logic [7:0]  in_dest;
	logic [1:0]  in_cmd;
	logic [31:0] in_addr;
	logic [12:0] in_len;
	logic        in_bc;
	logic        in_red;
	logic [7:0]  in_byte;
	logic        in_fire;
	logic        is_header;
	logic [12:0] len_sat;

	// Byte path
	logic [3:0]  fill_inc;
	logic [12:0] taken_inc;
	logic [63:0] chunk_new;
	logic        chunk_full;
	logic        last_byte;

	// Queue interface
	logic [1:0]  push_n;
	flit_t       flit0;
	flit_t       flit1;
	flit_t       head;
	logic        room2;

	assign in_dest   = s_tdata[7:0];
	assign in_cmd    = s_tdata[9:8];
	assign in_addr   = s_tdata[41:10];
	assign in_len    = s_tdata[54:42];
	assign in_bc     = s_tdata[55];
	assign in_red    = s_tdata[56];
	assign in_byte   = s_tdata[64:57];
	assign is_header = (s_tuser[0] == OP_HEADER);

	assign s_tready = room2;
	assign in_fire  = s_tvalid && s_tready;

	// Length saturation at MAX_LENGTH
	assign len_sat = ({4'b0, in_len} > 17'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : in_len;

	// Byte lane insert and end-of-chunk / end-of-packet detection
	assign fill_inc   = chunk_fill_q + 4'd1;
	assign taken_inc  = bytes_taken_q + 13'd1;
	assign chunk_full = (fill_inc >= 4'(BYTES_PER_FLIT));
	assign last_byte  = (taken_inc >= held_length_q);

	for (genvar i = 0; i < 8; i++) begin : g_lane
		assign chunk_new[8*i +: 8] = (chunk_fill_q == 4'(i)) ? in_byte : chunk_q[8*i +: 8];
	end

	// Flits caused by the item at hand
	always_comb begin
		flit0             = '0;
		flit0.kind        = KIND_HEAD;
		flit0.source_node = node_id_q;
		if (is_header) begin
			flit0.dest       = in_dest;
			flit0.command    = in_cmd;
			flit0.address    = in_addr;
			flit0.length     = len_sat;
			flit0.broadcast  = in_bc;
			flit0.reduction  = in_red;
			flit0.seq_length = seq_total(len_sat);
		end else begin
			flit0.dest       = held_dest_q;
			flit0.command    = held_cmd_q;
			flit0.address    = held_addr_q;
			flit0.length     = held_length_q;
			flit0.broadcast  = held_bc_q;
			flit0.reduction  = held_red_q;
			flit0.seq_length = seq_total(held_length_q);
		end
		flit1      = flit0;
		flit1.kind = KIND_TAIL;
		push_n     = 2'd0;

		if (in_fire) begin
			if (is_header) begin
				flit1.seq_number = 10'd1;
				push_n           = (len_sat == 13'd0) ? 2'd2 : 2'd1;
			end else if (collecting_q && (chunk_full || last_byte)) begin
				flit0.kind        = KIND_BODY;
				flit0.seq_number  = next_seq_q;
				flit0.payload     = chunk_new;
				flit0.valid_bytes = fill_inc;
				flit1.seq_number  = next_seq_q + 10'd1;
				push_n            = last_byte ? 2'd2 : 2'd1;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_wr_en) begin
			node_id_q <= cfg_wr_data;
		end
	end

	// Packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q  <= 1'b0;
			held_dest_q   <= '0;
			held_cmd_q    <= '0;
			held_addr_q   <= '0;
			held_bc_q     <= 1'b0;
			held_red_q    <= 1'b0;
			held_length_q <= '0;
			bytes_taken_q <= '0;
			chunk_q       <= '0;
			chunk_fill_q  <= '0;
			next_seq_q    <= 10'd1;
		end else if (in_fire) begin
			if (is_header) begin
				held_dest_q   <= in_dest;
				held_cmd_q    <= in_cmd;
				held_addr_q   <= in_addr;
				held_bc_q     <= in_bc;
				held_red_q    <= in_red;
				held_length_q <= len_sat;
				bytes_taken_q <= '0;
				chunk_q       <= '0;
				chunk_fill_q  <= '0;
				next_seq_q    <= 10'd1;
				collecting_q  <= (len_sat != 13'd0);
			end else if (collecting_q) begin
				bytes_taken_q <= taken_inc;
				if (chunk_full || last_byte) begin
					chunk_q      <= '0;
					chunk_fill_q <= '0;
					next_seq_q   <= next_seq_q + 10'd1;
				end else begin
					chunk_q      <= chunk_new;
					chunk_fill_q <= fill_inc;
				end
				if (last_byte) begin
					collecting_q <= 1'b0;
				end
			end
		end
	end

	nfs_flit_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_d0    (flit0),
		.push_d1    (flit1),
		.pop        (m_tready),
		.head       (head),
		.head_valid (m_tvalid),
		.room2      (room2)
	);

	// Output packing
	assign m_tuser = head.kind;
	assign m_tdata = {7'b0, head.reduction, head.broadcast, head.valid_bytes, head.payload,
		head.length, head.address, head.command, head.seq_length, head.seq_number,
		head.dest, head.source_node};

`ifndef NO_ASSERTIONS
	a_taken_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (bytes_taken_q < held_length_q))
		else $error("collecting with all bytes already taken");

	a_fill_below_flit: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (chunk_fill_q < 4'(BYTES_PER_FLIT)))
		else $error("chunk fill reached a full flit without emitting");

	a_empty_pkt_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_header && len_sat == 13'd0) |=> !collecting_q)
		else $error("zero-length header left packet open");

	a_tail_with_body: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_header && push_n == 2'd2) |-> (flit0.kind == KIND_BODY))
		else $error("tail from a byte without a preceding body flit");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for noc_packet_to_flit_splitter: predicts every head, body and tail flit
// and checks each one against the block output. Depends on nfs_pkg and the splitter RTL.
`timescale 1ns / 1ps

module testbench
	import nfs_pkg::*;
();

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES = 4;

	// One input item before packing
	typedef struct {
		logic        op;
		logic [7:0]  dest;
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [12:0] len;
		logic        bcast;
		logic        reduce;
		logic [7:0]  pbyte;
	} tx_item_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [7:0]   cfg_wr_data = 8'd0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [71:0]  s_tdata = 72'd0;
	logic [0:0]   s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic [1:0]   m_tuser;

	noc_packet_to_flit_splitter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	// Predictor state: mirror of the packetizer
	logic [7:0]  my_node_id = 8'd0;
	logic        pk_active = 1'b0;
	logic [7:0]  pk_dest = 8'd0;
	logic [1:0]  pk_cmd = 2'd0;
	logic [31:0] pk_addr = 32'd0;
	logic        pk_bcast = 1'b0;
	logic        pk_reduce = 1'b0;
	logic [12:0] pk_len = 13'd0;
	logic [12:0] pk_taken = 13'd0;
	logic [63:0] pk_chunk = 64'd0;
	logic [3:0]  pk_fill = 4'd0;
	logic [9:0]  pk_seq = 10'd1;

	flit_t pending_flits[$];
	int    mismatches = 0;
	int    cycles = 0;
	int    tx_idle_pct = 0;
	int    rx_stall_pct = 0;

	initial forever #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d flits outstanding", cycles,
				pending_flits.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [9:0] flits_in_packet();
		int n;
		n = (int'(pk_len) + BYTES_PER_FLIT - 1) / BYTES_PER_FLIT + 2;
		return n[9:0];
	endfunction

	function automatic flit_t build_flit(logic [1:0] kind, logic [9:0] seq,
			logic [63:0] data, logic [3:0] vb);
		flit_t f;
		f.kind        = kind;
		f.source_node = my_node_id;
		f.dest        = pk_dest;
		f.seq_number  = seq;
		f.seq_length  = flits_in_packet();
		f.command     = pk_cmd;
		f.address     = pk_addr;
		f.length      = pk_len;
		f.payload     = data;
		f.valid_bytes = vb;
		f.broadcast   = pk_bcast;
		f.reduction   = pk_reduce;
		return f;
	endfunction

	// Update the mirror for one accepted item; queue the flits it causes
	task automatic predict_flits(input tx_item_t it, output bit used);
		logic [12:0] len;
		used = 1'b1;
		if (it.op == OP_HEADER) begin
			len = (it.len > 13'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : it.len;
			pk_dest   = it.dest;
			pk_cmd    = it.cmd;
			pk_addr   = it.addr;
			pk_bcast  = it.bcast;
			pk_reduce = it.reduce;
			pk_len    = len;
			pk_taken  = 13'd0;
			pk_chunk  = 64'd0;
			pk_fill   = 4'd0;
			pk_seq    = 10'd1;
			pending_flits.push_back(build_flit(KIND_HEAD, 10'd0, 64'd0, 4'd0));
			if (len == 13'd0) begin
				pending_flits.push_back(build_flit(KIND_TAIL, pk_seq, 64'd0, 4'd0));
				pk_active = 1'b0;
			end else begin
				pk_active = 1'b1;
			end
		end else if (!pk_active) begin
			used = 1'b0;
		end else begin
			pk_chunk[8 * int'(pk_fill) +: 8] = it.pbyte;
			pk_fill  = pk_fill + 4'd1;
			pk_taken = pk_taken + 13'd1;
			if (pk_fill == 4'(BYTES_PER_FLIT) || pk_taken >= pk_len) begin
				pending_flits.push_back(build_flit(KIND_BODY, pk_seq, pk_chunk, pk_fill));
				pk_seq   = pk_seq + 10'd1;
				pk_chunk = 64'd0;
				pk_fill  = 4'd0;
			end
			if (pk_taken >= pk_len) begin
				pending_flits.push_back(build_flit(KIND_TAIL, pk_seq, 64'd0, 4'd0));
				pk_active = 1'b0;
			end
		end
	endtask

	// Compare one field, report and count on mismatch
	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want) begin
			$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycles, name, got, want);
			mismatches++;
		end
	endtask

	// Flit checker and receiver stalls
	always @(posedge clk) begin
		flit_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (pending_flits.size() == 0) begin
					check_field("unexpected flit, kind", 64'(m_tuser), 64'hx);
				end else begin
					w = pending_flits.pop_front();
					check_field("flit_kind", 64'(m_tuser), 64'(w.kind));
					check_field("source_node", 64'(m_tdata[7:0]), 64'(w.source_node));
					check_field("flit_dest", 64'(m_tdata[15:8]), 64'(w.dest));
					check_field("seq_number", 64'(m_tdata[25:16]), 64'(w.seq_number));
					check_field("seq_length", 64'(m_tdata[35:26]), 64'(w.seq_length));
					check_field("flit_command", 64'(m_tdata[37:36]), 64'(w.command));
					check_field("flit_address", 64'(m_tdata[69:38]), 64'(w.address));
					check_field("flit_length", 64'(m_tdata[82:70]), 64'(w.length));
					check_field("payload", m_tdata[146:83], w.payload);
					check_field("valid_bytes", 64'(m_tdata[150:147]), 64'(w.valid_bytes));
					check_field("bcast_flag", 64'(m_tdata[151]), 64'(w.broadcast));
					check_field("flit_reduction", 64'(m_tdata[152]), 64'(w.reduction));
				end
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	function automatic tx_item_t make_header(logic [7:0] dest, logic [1:0] cmd,
			logic [31:0] addr, logic [12:0] len, logic bcast, logic reduce);
		tx_item_t it;
		it.op     = OP_HEADER;
		it.dest   = dest;
		it.cmd    = cmd;
		it.addr   = addr;
		it.len    = len;
		it.bcast  = bcast;
		it.reduce = reduce;
		it.pbyte  = 8'($urandom);
		return it;
	endfunction

	function automatic tx_item_t random_header(logic [12:0] len);
		return make_header(8'($urandom), 2'($urandom), $urandom, len,
			1'($urandom), 1'($urandom));
	endfunction

	// Byte item; header fields carry noise
	function automatic tx_item_t make_byte(logic [7:0] b);
		tx_item_t it;
		it       = random_header(13'($urandom));
		it.op    = OP_BYTE;
		it.pbyte = b;
		return it;
	endfunction

	// Send one item, with random idle cycles first
	task automatic send_item(input tx_item_t it, output bit used);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.op;
		s_tdata  <= {7'd0, it.pbyte, it.reduce, it.bcast, it.len, it.addr, it.cmd, it.dest};
		do @(posedge clk); while (s_tready !== 1'b1);
		predict_flits(it, used);
	endtask

	// Header followed by nbytes random payload bytes; returns items that mattered
	task automatic send_packet(input tx_item_t hdr, input int nbytes, output int used_cnt);
		bit used;
		send_item(hdr, used);
		used_cnt = int'(used);
		for (int i = 0; i < nbytes; i++) begin
			send_item(make_byte(8'($urandom)), used);
			used_cnt += int'(used);
		end
	endtask

	// Stop sending and wait until every predicted flit has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_flits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_id(input logic [7:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		my_node_id  = v;
	endtask

	// Field extremes, every command code, short lengths around a flit boundary
	task automatic test_header_fields();
		int  n;
		bit  used;
		send_packet(make_header(8'h00, 2'd0, 32'h0000_0000, 13'd0, 1'b0, 1'b0), 0, n);
		send_packet(make_header(8'hFF, 2'd1, 32'hFFFF_FFFF, 13'd1, 1'b1, 1'b1), 1, n);
		send_packet(make_header(8'h5A, 2'd2, 32'hA5A5_5A5A, 13'd7, 1'b1, 1'b0), 7, n);
		send_packet(make_header(8'hA5, 2'd3, 32'h1234_5678, 13'd8, 1'b0, 1'b1), 8, n);
		send_packet(make_header(8'h3C, 2'd1, 32'h8000_0001, 13'd9, 1'b0, 1'b0), 9, n);
		// extreme byte values
		send_item(make_header(8'h01, 2'd1, 32'h0000_00FF, 13'd2, 1'b0, 1'b0), used);
		send_item(make_byte(8'h00), used);
		send_item(make_byte(8'hFF), used);
		wait_drained();
	endtask

	// Bytes with no open packet and bytes beyond the length are dropped
	task automatic test_stray_bytes();
		int n;
		bit used;
		send_item(make_byte(8'h11), used);
		send_item(make_byte(8'hEE), used);
		send_packet(random_header(13'd3), 6, n);
		wait_drained();
	endtask

	// A new header abandons the packet in progress and its partial chunk
	task automatic test_abandoned_packet();
		int n;
		send_packet(random_header(13'd20), 11, n);
		send_packet(random_header(13'd2), 2, n);
		send_packet(random_header(13'd4096), 3, n);
		send_packet(random_header(13'd0), 0, n);
		wait_drained();
	endtask

	// Oversized lengths saturate; every flit carries the maximum length and flit count
	task automatic test_max_length();
		int n;
		send_packet(make_header(8'hC3, 2'd1, 32'hDEAD_BEEF, 13'h1FFF, 1'b1, 1'b0), 19, n);
		send_packet(make_header(8'h3C, 2'd2, 32'h0BAD_F00D, 13'h1001, 1'b0, 1'b1), 9, n);
		wait_drained();
	endtask

	// Mostly well-formed packets with random content, some broken ones and noise
	task automatic test_random_traffic(input int idle, input int stall, input int n_items);
		int          sent;
		int          n;
		int          pick;
		int          nbytes;
		logic [12:0] len;
		tx_idle_pct  = idle;
		rx_stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 70)      len = 13'($urandom_range(24));
			else if (pick < 90) len = 13'($urandom_range(80, 25));
			else if (pick < 98) len = 13'($urandom_range(4095, 81));
			else                len = 13'($urandom_range(8191, 4096));
			pick = $urandom_range(99);
			if (len > 13'd80)    nbytes = $urandom_range(20);
			else if (pick < 80)  nbytes = int'(len);
			else if (pick < 90)  nbytes = $urandom_range(int'(len));
			else                 nbytes = int'(len) + $urandom_range(3, 1);
			send_packet(random_header(len), nbytes, n);
			sent += n;
			if ($urandom_range(99) == 0) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_node_id(8'hA5);
		test_header_fields();
		test_stray_bytes();
		test_abandoned_packet();
		tx_idle_pct  = 16;
		rx_stall_pct = 16;
		test_max_length();
		write_node_id(8'h00);
		test_random_traffic(0, 0, 500);
		write_node_id(8'hFF);
		test_random_traffic(80, 0, 500);
		write_node_id(8'($urandom));
		test_random_traffic(0, 80, 500);
		write_node_id(8'($urandom));
		test_random_traffic(16, 16, 500);
		if (pending_flits.size() != 0)
			check_field("flits never seen", 64'(pending_flits.size()), 64'd0);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
